FILE: rtl/atp_pkg.sv
// ============================================================================
// atp_pkg
// Shared types, constants and the arctangent table of the tilt sensor block.
// ============================================================================
`default_nettype none

package atp_pkg;

   localparam int SAMPLE_W   = 10;
   localparam int OFFSET_W   = 14;
   localparam int SUM_W      = 22;
   localparam int TILT_W     = 15;
   localparam int DIFF_W     = 16;
   localparam int SQ_W       = 30;
   localparam int RAD_W      = 48;
   localparam int ROOT_W     = 24;
   localparam int REM_W      = 26;
   localparam int CORD_W     = 27;
   localparam int ANG_W      = 25;
   localparam int DIV_W      = SUM_W + 5;
   localparam int DIV_STEPS  = DIV_W;
   localparam int SQRT_STEPS = RAD_W / 2;
   localparam int STEP_W     = 5;
   localparam int TILT_LIMIT = 9000;
   localparam logic [OFFSET_W-1:0] Z_OFFSET_RESET = 14'd5811;

   typedef enum logic [1:0] {
      OP_RESTART  = 2'd0,
      OP_ADD      = 2'd1,
      OP_FINALIZE = 2'd2,
      OP_MEASURE  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV,
      ST_DIV_END,
      ST_DIFF,
      ST_SQUARE,
      ST_SUM,
      ST_SQRT,
      ST_CORDIC_INIT,
      ST_CORDIC,
      ST_ANGLE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              load;
      logic              restart;
      logic              add;
      logic              empty;
      logic              div_init;
      logic              div_step;
      logic              div_commit;
      logic              diff;
      logic              square;
      logic              sum;
      logic              sqrt_step;
      logic              cordic_init;
      logic              cordic_step;
      logic              angle;
      logic              out_load;
      logic [STEP_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   count_zero;
   } sts_type;

   // arctan(2^-i) in hundredths of a degree times 256
   function automatic logic [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
      logic [ANG_W-1:0] v;
      case (i)
         5'd0:    v = 25'd1152000;
         5'd1:    v = 25'd680065;
         5'd2:    v = 25'd359328;
         5'd3:    v = 25'd182400;
         5'd4:    v = 25'd91554;
         5'd5:    v = 25'd45822;
         5'd6:    v = 25'd22916;
         5'd7:    v = 25'd11459;
         5'd8:    v = 25'd5730;
         5'd9:    v = 25'd2865;
         5'd10:   v = 25'd1432;
         5'd11:   v = 25'd716;
         5'd12:   v = 25'd358;
         5'd13:   v = 25'd179;
         5'd14:   v = 25'd90;
         5'd15:   v = 25'd45;
         5'd16:   v = 25'd22;
         5'd17:   v = 25'd11;
         5'd18:   v = 25'd6;
         5'd19:   v = 25'd3;
         5'd20:   v = 25'd1;
         5'd21:   v = 25'd1;
         default: v = 25'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/atp_ctrl.sv
// ============================================================================
// atp_ctrl
// Sequencer: decodes the operation and steps the datapath through it.
// ============================================================================
`default_nettype none

module atp_ctrl #(
   parameter int CORDIC_ITERS = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire atp_pkg::sts_type sts,
   output atp_pkg::cmd_type     cmd
);
   import atp_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              div_last, sqrt_last, cordic_last;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign div_last    = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign sqrt_last   = (step_ff == STEP_W'(SQRT_STEPS - 1));
   assign cordic_last = (step_ff == STEP_W'(CORDIC_ITERS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:        if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            case (sts.op)
               OP_FINALIZE: state_in = sts.count_zero ? ST_DONE : ST_DIV;
               OP_MEASURE:  state_in = ST_DIFF;
               default:     state_in = ST_DONE;
            endcase
         end
         ST_DIV:         if (div_last) state_in = ST_DIV_END;
         ST_DIV_END:     state_in = ST_DONE;
         ST_DIFF:        state_in = ST_SQUARE;
         ST_SQUARE:      state_in = ST_SUM;
         ST_SUM:         state_in = ST_SQRT;
         ST_SQRT:        if (sqrt_last) state_in = ST_CORDIC_INIT;
         ST_CORDIC_INIT: state_in = ST_CORDIC;
         ST_CORDIC:      if (cordic_last) state_in = ST_ANGLE;
         ST_ANGLE:       state_in = ST_DONE;
         ST_DONE:        if (out_free) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.idx      = step_ff;
      step_in      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DECODE: begin
            case (sts.op)
               OP_RESTART:  cmd.restart = 1'b1;
               OP_ADD:      cmd.add     = 1'b1;
               OP_FINALIZE: begin
                  cmd.empty    = sts.count_zero;
                  cmd.div_init = !sts.count_zero;
               end
               default:     cmd.diff = 1'b0;
            endcase
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
         end
         ST_DIV_END:     cmd.div_commit = 1'b1;
         ST_DIFF:        cmd.diff = 1'b1;
         ST_SQUARE:      cmd.square = 1'b1;
         ST_SUM:         cmd.sum = 1'b1;
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff + 1'b1;
         end
         ST_CORDIC_INIT: cmd.cordic_init = 1'b1;
         ST_CORDIC: begin
            cmd.cordic_step = 1'b1;
            step_in         = step_ff + 1'b1;
         end
         ST_ANGLE:       cmd.angle = 1'b1;
         ST_DONE: begin
            cmd.out_load = out_free;
            if (out_free) rsp_valid_in = 1'b1;
         end
         default:        cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/atp_dp.sv
// ============================================================================
// atp_dp
// Datapath: calibration sums, offset divider, square roots and CORDIC.
// ============================================================================
`default_nettype none

module atp_dp #(
   parameter int MAX_CAL_SAMPLES = 4096,
   parameter int ADC_BITS        = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire atp_pkg::cmd_type                  cmd,
   output atp_pkg::sts_type                       sts,
   input  wire logic [1:0]                        req_operation,
   input  wire logic [atp_pkg::SAMPLE_W-1:0]      req_sample_x,
   input  wire logic [atp_pkg::SAMPLE_W-1:0]      req_sample_y,
   input  wire logic [atp_pkg::SAMPLE_W-1:0]      req_sample_z,
   input  wire logic                              csr_write_enable,
   input  wire logic [atp_pkg::OFFSET_W-1:0]      csr_write_data,
   output logic signed [atp_pkg::TILT_W-1:0]      rsp_tilt_x,
   output logic signed [atp_pkg::TILT_W-1:0]      rsp_tilt_y,
   output logic                                   rsp_is_calibrated,
   output logic                                   rsp_status
);
   import atp_pkg::*;

   localparam int CW = $clog2(MAX_CAL_SAMPLES + 1);

   logic [SAMPLE_W-1:0] smask;
   always_comb begin
      for (int i = 0; i < SAMPLE_W; i++) smask[i] = (i < ADC_BITS);
   end

   // latched transaction
   op_type              op_ff;
   logic [SAMPLE_W-1:0] sx_ff, sy_ff, sz_ff;

   // architectural state
   logic [OFFSET_W-1:0]      z_off_ff, off_x_ff, off_y_ff;
   logic [SUM_W-1:0]         sum_x_ff, sum_y_ff;
   logic [CW-1:0]            count_ff;
   logic                     cal_ff, status_ff;
   logic signed [TILT_W-1:0] last_x_ff, last_y_ff, ang_x, ang_y;

   // divider
   logic [CW:0]      rem_x_ff, rem_y_ff, dr_x, dr_y;
   logic [DIV_W-1:0] quo_x_ff, quo_y_ff, dividend_x, dividend_y;

   // measure pipeline
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic [SQ_W-1:0]          dx2_ff, dy2_ff, dz2_ff;
   logic [RAD_W-1:0]         rad_x_ff, rad_y_ff;
   logic [REM_W-1:0]         srem_x_ff, srem_y_ff;
   logic [ROOT_W-1:0]        root_x_ff, root_y_ff;
   logic [97:0]              sq_nx, sq_ny;
   logic signed [CORD_W-1:0] cx_ff, cy_ff, ax_ff, ay_ff;
   logic signed [ANG_W-1:0]  zx_ff, zy_ff;
   logic                     nzx_ff, nzy_ff;
   logic signed [31:0]       px, py, pz;

   function automatic logic [97:0] sqrt_next(input logic [RAD_W-1:0] rad,
                                             input logic [REM_W-1:0] rem,
                                             input logic [ROOT_W-1:0] root);
      logic [REM_W+1:0] r;
      logic [REM_W+1:0] t;
      r = {rem, rad[RAD_W-1 -: 2]};
      t = {2'b00, root, 2'b01};
      if (r >= t) return {rad << 2, REM_W'(r - t), {root[ROOT_W-2:0], 1'b1}};
      return {rad << 2, REM_W'(r), {root[ROOT_W-2:0], 1'b0}};
   endfunction

   // one vectoring rotation; returns {x, y, z}
   function automatic logic [2*CORD_W+ANG_W-1:0] cordic_next(
      input logic signed [CORD_W-1:0] x, input logic signed [CORD_W-1:0] y,
      input logic signed [ANG_W-1:0] z, input logic [STEP_W-1:0] i);
      logic signed [CORD_W-1:0] xs, ys;
      xs = x >>> i;
      ys = y >>> i;
      if (!y[CORD_W-1] && (y != '0))
         return {x + ys, y - xs, z + $signed(atan_entry(i))};
      return {x - ys, y + xs, z - $signed(atan_entry(i))};
   endfunction

   // round to hundredths, negate, clamp
   function automatic logic signed [TILT_W-1:0] to_tilt(input logic signed [ANG_W-1:0] z,
                                                       input logic nz);
      logic signed [ANG_W-1:0] zr;
      zr = (z + ANG_W'(128)) >>> 8;
      if (!nz) return '0;
      if (zr > ANG_W'(TILT_LIMIT)) return -TILT_W'(TILT_LIMIT);
      if (zr < -ANG_W'(TILT_LIMIT)) return TILT_W'(TILT_LIMIT);
      return TILT_W'(-zr);
   endfunction

   assign sts.op         = op_ff;
   assign sts.count_zero = (count_ff == '0);

   assign dividend_x = {1'b0, sum_x_ff, 4'b0000} + DIV_W'(count_ff >> 1);
   assign dividend_y = {1'b0, sum_y_ff, 4'b0000} + DIV_W'(count_ff >> 1);
   assign dr_x = {rem_x_ff[CW-1:0], quo_x_ff[DIV_W-1]};
   assign dr_y = {rem_y_ff[CW-1:0], quo_y_ff[DIV_W-1]};

   assign px = dx_ff * dx_ff;
   assign py = dy_ff * dy_ff;
   assign pz = dz_ff * dz_ff;
   assign sq_nx = sqrt_next(rad_x_ff, srem_x_ff, root_x_ff);
   assign sq_ny = sqrt_next(rad_y_ff, srem_y_ff, root_y_ff);
   assign ang_x = to_tilt(zx_ff, nzx_ff);
   assign ang_y = to_tilt(zy_ff, nzy_ff);

   // state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         z_off_ff  <= Z_OFFSET_RESET;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         count_ff  <= '0;
         off_x_ff  <= '0;
         off_y_ff  <= '0;
         cal_ff    <= 1'b0;
         status_ff <= 1'b0;
         last_x_ff <= '0;
         last_y_ff <= '0;
         op_ff     <= OP_RESTART;
      end else begin
         if (csr_write_enable) z_off_ff <= csr_write_data;
         if (cmd.load) begin
            op_ff     <= op_type'(req_operation);
            status_ff <= 1'b0;
         end
         if (cmd.restart) begin
            sum_x_ff <= '0;
            sum_y_ff <= '0;
            count_ff <= '0;
            cal_ff   <= 1'b0;
         end
         if (cmd.add && (count_ff < CW'(MAX_CAL_SAMPLES))) begin
            sum_x_ff <= sum_x_ff + SUM_W'(sx_ff);
            sum_y_ff <= sum_y_ff + SUM_W'(sy_ff);
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.empty) status_ff <= 1'b1;
         if (cmd.div_commit) begin
            off_x_ff <= quo_x_ff[OFFSET_W-1:0];
            off_y_ff <= quo_y_ff[OFFSET_W-1:0];
            cal_ff   <= 1'b1;
         end
         if (cmd.angle) begin
            last_x_ff <= ang_x;
            last_y_ff <= ang_y;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sx_ff <= req_sample_x & smask;
         sy_ff <= req_sample_y & smask;
         sz_ff <= req_sample_z & smask;
      end
      if (cmd.div_init) begin
         rem_x_ff <= '0;
         rem_y_ff <= '0;
         quo_x_ff <= dividend_x;
         quo_y_ff <= dividend_y;
      end
      if (cmd.div_step) begin
         rem_x_ff <= (dr_x >= {1'b0, count_ff}) ? dr_x - {1'b0, count_ff} : dr_x;
         rem_y_ff <= (dr_y >= {1'b0, count_ff}) ? dr_y - {1'b0, count_ff} : dr_y;
         quo_x_ff <= {quo_x_ff[DIV_W-2:0], (dr_x >= {1'b0, count_ff})};
         quo_y_ff <= {quo_y_ff[DIV_W-2:0], (dr_y >= {1'b0, count_ff})};
      end
      if (cmd.diff) begin
         dx_ff <= $signed({2'b00, sx_ff, 4'b0000}) - $signed({2'b00, off_x_ff});
         dy_ff <= $signed({2'b00, sy_ff, 4'b0000}) - $signed({2'b00, off_y_ff});
         dz_ff <= $signed({2'b00, sz_ff, 4'b0000}) - $signed({2'b00, z_off_ff});
      end
      if (cmd.square) begin
         dx2_ff <= px[SQ_W-1:0];
         dy2_ff <= py[SQ_W-1:0];
         dz2_ff <= pz[SQ_W-1:0];
      end
      if (cmd.sum) begin
         rad_x_ff  <= {1'b0, {1'b0, dx2_ff} + {1'b0, dz2_ff}, 16'h0000};
         rad_y_ff  <= {1'b0, {1'b0, dy2_ff} + {1'b0, dz2_ff}, 16'h0000};
         srem_x_ff <= '0;
         srem_y_ff <= '0;
         root_x_ff <= '0;
         root_y_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         {rad_x_ff, srem_x_ff, root_x_ff} <= sq_nx;
         {rad_y_ff, srem_y_ff, root_y_ff} <= sq_ny;
      end
      if (cmd.cordic_init) begin
         // X tilt: numerator dx against root of dy,dz; Y tilt the other way
         cx_ff  <= $signed({3'b000, root_y_ff});
         ax_ff  <= $signed({{3{dx_ff[DIFF_W-1]}}, dx_ff, 8'h00});
         zx_ff  <= '0;
         nzx_ff <= (dx_ff != '0);
         cy_ff  <= $signed({3'b000, root_x_ff});
         ay_ff  <= $signed({{3{dy_ff[DIFF_W-1]}}, dy_ff, 8'h00});
         zy_ff  <= '0;
         nzy_ff <= (dy_ff != '0);
      end
      if (cmd.cordic_step) begin
         {cx_ff, ax_ff, zx_ff} <= cordic_next(cx_ff, ax_ff, zx_ff, cmd.idx);
         {cy_ff, ay_ff, zy_ff} <= cordic_next(cy_ff, ay_ff, zy_ff, cmd.idx);
      end
      if (cmd.out_load) begin
         rsp_tilt_x        <= last_x_ff;
         rsp_tilt_y        <= last_y_ff;
         rsp_is_calibrated <= cal_ff;
         rsp_status        <= status_ff;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/accel_tilt_with_zero_calibration.sv
// ============================================================================
// accel_tilt_with_zero_calibration
// Accelerometer tilt angles with X/Y zero-g calibration.
// ============================================================================
// Usage:
//  - Input channel req_*: one transaction carries an operation and three
//    ADC samples. Restart clears the calibration sums; add accumulates X/Y;
//    finalize sets the X/Y zero offsets to the rounded average (status 1
//    if nothing was accumulated); measure returns two tilt angles.
//  - Result channel rsp_*: exactly one transaction per input transaction,
//    carrying the latest tilts, the calibrated flag and status.
//  - csr_*: writes the Z zero-g offset (Q.4 counts); write only while idle.
//  - Sequence: finalize runs a divider at one quotient bit per cycle;
//    measure forms differences, squares and sums, then takes one root bit
//    per cycle and one CORDIC rotation per cycle.
//  - Throughput: one transaction at a time; req_ready is high only when the
//    sequencer is idle. The result sits in an output register, so the
//    next transaction is taken while a result waits.
//  - Stall: if the previous result has not been taken, the finished
//    transaction holds in its last step until rsp_ready frees the register.
//  - Reset: all calibration state and tilts clear, Z offset returns to 5811.
// ============================================================================
`default_nettype none

module accel_tilt_with_zero_calibration #(
   parameter int MAX_CAL_SAMPLES = 4096,
   parameter int ADC_BITS        = 10,
   parameter int CORDIC_ITERS    = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_operation,
   input  wire logic [atp_pkg::SAMPLE_W-1:0]      req_sample_x,
   input  wire logic [atp_pkg::SAMPLE_W-1:0]      req_sample_y,
   input  wire logic [atp_pkg::SAMPLE_W-1:0]      req_sample_z,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [atp_pkg::TILT_W-1:0]      rsp_tilt_x,
   output logic signed [atp_pkg::TILT_W-1:0]      rsp_tilt_y,
   output logic                                   rsp_is_calibrated,
   output logic                                   rsp_status,
   input  wire logic                              csr_write_enable,
   input  wire logic [atp_pkg::OFFSET_W-1:0]      csr_write_data
);
   import atp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   atp_ctrl #(
      .CORDIC_ITERS (CORDIC_ITERS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic and calibration state
   atp_dp #(
      .MAX_CAL_SAMPLES (MAX_CAL_SAMPLES),
      .ADC_BITS        (ADC_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_sample_x      (req_sample_x),
      .req_sample_y      (req_sample_y),
      .req_sample_z      (req_sample_z),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_tilt_x        (rsp_tilt_x),
      .rsp_tilt_y        (rsp_tilt_y),
      .rsp_is_calibrated (rsp_is_calibrated),
      .rsp_status        (rsp_status)
   );

endmodule

`default_nettype wire
